@@ sv/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// AES encryption package
// Shared types, constants and byte-level functions for the AES block encryptor.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

    localparam int RK_ROWS = 15;
    localparam int RK_ROW_AW = 4;
    localparam int WIN_DEPTH = 8;

    localparam logic [3:0] NR_128 = 4'd10;
    localparam logic [3:0] NR_256 = 4'd14;

    localparam logic [5:0] RK_LAST_128 = 6'd43;
    localparam logic [5:0] RK_LAST_256 = 6'd59;

    localparam logic [7:0] GF_POLY = 8'h1b;
    localparam logic [7:0] RCON_INIT = 8'h01;

    localparam logic [2:0] REG_KEY_WORD_0 = 3'd0;
    localparam logic [2:0] REG_KEY_WORD_1 = 3'd1;
    localparam logic [2:0] REG_KEY_WORD_2 = 3'd2;
    localparam logic [2:0] REG_KEY_WORD_3 = 3'd3;
    localparam logic [2:0] REG_KEY_SIZE = 3'd4;

    typedef enum logic
    {
        ST_IDLE,
        ST_ROUND
    } enc_state_t;

    typedef struct packed
    {
        logic                 we;
        logic [RK_ROW_AW-1:0] addr;
        logic [127:0]         data;
    } rk_wr_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX[b];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_bytes(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

`default_nettype wire

@@ sv/aes_rk_ram.sv @@
// ----------------------------------------------------------------------------
// AES round key RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_rk_ram #(
    parameter int DATA_W = 128,
    parameter int DEPTH = 15,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/aes_key_expand.sv @@
// ----------------------------------------------------------------------------
// AES key expansion sequencer
// Produces one schedule word per cycle and writes each finished 128-bit row.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_key_expand import aes_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [7:0][31:0] key,
    input  wire logic             key_size,
    output logic                  busy,
    output rk_wr_t                wr
);

    logic [5:0]  i_reg, i_next;
    logic        busy_reg, busy_next;
    logic [7:0]  rc_reg, rc_next;
    logic [31:0] win_reg [WIN_DEPTH];
    logic [95:0] acc_reg;

    logic        is_key;
    logic        phase;
    logic        half;
    logic [2:0]  kidx;
    logic [31:0] prev;
    logic [31:0] older;
    logic [31:0] tmp;
    logic [31:0] word;
    logic [5:0]  last;

    always_comb
    begin
        is_key = (i_reg[5:3] == 3'd0) && (key_size || !i_reg[2]);
        phase = key_size ? (i_reg[2:0] == 3'd0) : (i_reg[1:0] == 2'd0);
        half = key_size && (i_reg[2:0] == 3'd4);
        kidx = 3'd7 - i_reg[2:0];
        prev = win_reg[WIN_DEPTH-1];
        older = key_size ? win_reg[0] : win_reg[WIN_DEPTH-4];
        last = key_size ? RK_LAST_256 : RK_LAST_128;

        if (phase)
        begin
            tmp = sbox_bytes({prev[23:0], prev[31:24]}) ^ {rc_reg, 24'd0};
        end
        else if (half)
        begin
            tmp = sbox_bytes(prev);
        end
        else
        begin
            tmp = prev;
        end

        word = is_key ? key[kidx] : (older ^ tmp);

        i_next = i_reg;
        busy_next = busy_reg;
        rc_next = rc_reg;
        if (start)
        begin
            i_next = 6'd0;
            busy_next = 1'b1;
            rc_next = RCON_INIT;
        end
        else if (busy_reg)
        begin
            i_next = i_reg + 6'd1;
            busy_next = (i_reg != last);
            if (!is_key && phase)
            begin
                rc_next = xtime(rc_reg);
            end
        end

        wr.we = busy_reg && !start && (i_reg[1:0] == 2'b11);
        wr.addr = i_reg[5:2];
        wr.data = {acc_reg, word};
        busy = busy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= 6'd0;
            busy_reg <= 1'b0;
            rc_reg <= RCON_INIT;
        end
        else
        begin
            i_reg <= i_next;
            busy_reg <= busy_next;
            rc_reg <= rc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !start)
        begin
            for (int j = 0; j < WIN_DEPTH - 1; j++)
            begin
                win_reg[j] <= win_reg[j+1];
            end
            win_reg[WIN_DEPTH-1] <= word;
            acc_reg <= {acc_reg[63:0], word};
        end
    end

endmodule

`default_nettype wire

@@ sv/aes_round.sv @@
// ----------------------------------------------------------------------------
// AES round unit
// One cipher round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey; with bypass, AddRoundKey alone.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_round import aes_pkg::*; (
    input  wire logic [127:0] state,
    input  wire logic [127:0] round_key,
    input  wire logic         bypass,
    input  wire logic         mix_en,
    output logic      [127:0] result
);

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] all;
    logic [127:0] packed_m;

    // Byte 4*c+r is row r of column c, byte 0 in the most significant bits.
    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            s[k] = state[127 - 8*k -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[4*c + r] = sbox(s[4*((c + r) % 4) + r]);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            for (int r = 0; r < 4; r++)
            begin
                if (mix_en)
                begin
                    m[4*c + r] = t[4*c + r] ^ all
                               ^ xtime(t[4*c + r] ^ t[4*c + ((r + 1) % 4)]);
                end
                else
                begin
                    m[4*c + r] = t[4*c + r];
                end
            end
        end
        for (int k = 0; k < 16; k++)
        begin
            packed_m[127 - 8*k -: 8] = m[k];
        end
        result = (bypass ? state : packed_m) ^ round_key;
    end

endmodule

`default_nettype wire

@@ sv/aes_block_encrypt_unit.sv @@
// ----------------------------------------------------------------------------
// AES block encryption unit
// Encrypts 128-bit blocks (AES-128/256), a round per cycle unless output stalls.
// ----------------------------------------------------------------------------
// A single shared round unit runs AddRoundKey, then Nr rounds (Nr = 10 or 14).
// A new item is accepted only in the idle state, after the last round is done.
// After reset and after each write to a key or key-size register the key
// schedule runs, one word per cycle, with in_ready low.
// Reset clears the key registers to zero and starts a key expansion.
`default_nettype none

module aes_block_encrypt_unit import aes_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] plaintext_high,
    input  wire logic [63:0] plaintext_low,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [63:0] ciphertext_high,
    output logic      [63:0] ciphertext_low
);

    logic [3:0][63:0] key_reg;
    logic             key_size_reg;
    logic             pend_reg, pend_next;
    enc_state_t       state_reg, state_next;
    logic [3:0]       rnd_reg, rnd_next;
    logic [127:0]     blk_reg, blk_next;
    logic             out_valid_reg, out_valid_next;
    logic [127:0]     out_reg;
    logic             out_load;

    logic             cfg_hit;
    logic             exp_start;
    logic             exp_busy;
    rk_wr_t           rk_wr;
    logic             rd_en;
    logic [RK_ROW_AW-1:0] rd_addr;
    logic [127:0]     rk_data;
    logic [127:0]     round_out;
    logic [3:0]       nr;
    logic             last_rnd;
    logic             accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            key_size_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KEY_WORD_0: key_reg[3] <= cfg_data;
                REG_KEY_WORD_1: key_reg[2] <= cfg_data;
                REG_KEY_WORD_2: key_reg[1] <= cfg_data;
                REG_KEY_WORD_3: key_reg[0] <= cfg_data;
                REG_KEY_SIZE:   key_size_reg <= cfg_data[0];
                default:        key_size_reg <= key_size_reg;
            endcase
        end
    end

    aes_key_expand u_expand (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (exp_start),
        .key      (key_reg),
        .key_size (key_size_reg),
        .busy     (exp_busy),
        .wr       (rk_wr)
    );

    aes_rk_ram #(
        .DATA_W (128),
        .DEPTH  (RK_ROWS)
    ) u_rk_ram (
        .clk   (clk),
        .we    (rk_wr.we),
        .waddr (rk_wr.addr),
        .wdata (rk_wr.data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rk_data)
    );

    aes_round u_round (
        .state     (blk_reg),
        .round_key (rk_data),
        .bypass    (rnd_reg == 4'd0),
        .mix_en    (!last_rnd),
        .result    (round_out)
    );

    always_comb
    begin
        cfg_hit = cfg_write && (cfg_index == REG_KEY_WORD_0 || cfg_index == REG_KEY_WORD_1
                  || cfg_index == REG_KEY_WORD_2 || cfg_index == REG_KEY_WORD_3
                  || cfg_index == REG_KEY_SIZE);
        exp_start = pend_reg && (state_reg == ST_IDLE);
        pend_next = cfg_hit ? 1'b1 : (exp_start ? 1'b0 : pend_reg);

        nr = key_size_reg ? NR_256 : NR_128;
        last_rnd = (rnd_reg == nr);
        in_ready = (state_reg == ST_IDLE) && !pend_reg && !exp_busy;
        accept = in_valid && in_ready;

        state_next = state_reg;
        rnd_next = rnd_reg;
        blk_next = blk_reg;
        rd_en = 1'b0;
        rd_addr = '0;
        out_load = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_ROUND;
                    rnd_next = 4'd0;
                    blk_next = {plaintext_high, plaintext_low};
                    rd_en = 1'b1;
                end
            end
            ST_ROUND:
            begin
                if (!(last_rnd && out_valid_reg && !out_ready))
                begin
                    blk_next = round_out;
                    rnd_next = rnd_reg + 4'd1;
                    rd_en = !last_rnd;
                    rd_addr = rnd_reg + 4'd1;
                    if (last_rnd)
                    begin
                        out_load = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        out_valid = out_valid_reg;
        ciphertext_high = out_reg[127:64];
        ciphertext_low = out_reg[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b1;
            state_reg <= ST_IDLE;
            rnd_reg <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            state_reg <= state_next;
            rnd_reg <= rnd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        if (out_load)
        begin
            out_reg <= round_out;
        end
    end

endmodule

`default_nettype wire

@@ tb/aes_block_encrypt_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for the AES block encryption unit
// Drives plaintext blocks through the valid/ready input channel and checks
// every ciphertext block against a published value where the script gives one,
// else against an in-bench AES-128/AES-256 encryptor that follows each key
// register write. A short scripted part covers the published test vectors,
// all-zero and all-one keys and data, unused key words, key size values with
// junk upper bits and writes to unmapped register indexes. It is followed by
// random blocks under random keys in three handshake idle profiles.
// ----------------------------------------------------------------------------
module aes_block_encrypt_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aes_pkg::*;

    localparam int CLK_HALF = 2;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_GAP = 50;
    localparam int PHASES_PER_MODE = 4;
    localparam int BLOCKS_PER_PHASE = 66;
    localparam int REPORT_LIMIT = 10;

    localparam int AES128_ROUNDS = 10;
    localparam int AES256_ROUNDS = 14;
    localparam logic [7:0] REDUCE_POLY = 8'h1b;
    localparam logic [7:0] AFFINE_C = 8'h63;
    localparam logic [7:0] RCON_FIRST = 8'h01;

    localparam logic [2:0] REG_SPARE_5 = 3'd5;
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    localparam logic [2:0] KEY_WORD_REGS [4] =
        '{REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3};
    localparam logic [2:0] SPARE_REGS [3] = '{REG_SPARE_5, REG_SPARE_6, REG_SPARE_7};

    localparam int TX_IDLE_PCT [3] = '{21, 80, 0};
    localparam int RX_IDLE_PCT [3] = '{80, 21, 0};

    localparam logic [63:0]  ONES_64 = 64'hffff_ffff_ffff_ffff;
    localparam logic [127:0] ONES_128 = {ONES_64, ONES_64};
    localparam logic [127:0] FIPS_PT = 128'h00112233_44556677_8899aabb_ccddeeff;
    localparam logic [127:0] FIPS_CT_128 = 128'h69c4e0d8_6a7b0430_d8cdb780_70b4c55a;
    localparam logic [127:0] FIPS_CT_256 = 128'h8ea2b7ca_516745bf_eafc4990_4b496089;
    localparam logic [127:0] ZERO_CT_128 = 128'h66e94bd4_ef8a2c3b_884cfa59_ca342b2e;
    localparam logic [127:0] ZERO_CT_256 = 128'hdc95c078_a2408989_ad48a214_92842087;

    typedef enum bit
    {
        ROW_WRITE,
        ROW_BLOCK
    } row_kind_t;

    typedef struct packed
    {
        row_kind_t    kind;
        logic [2:0]   index;
        logic [63:0]  value;
        logic [127:0] block;
        logic         known;
        logic [127:0] cipher;
    } script_row_t;

    localparam int SCRIPT_ROWS = 39;
    localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
        '{ROW_BLOCK, '0, '0, '0, 1'b1, ZERO_CT_128},
        '{ROW_BLOCK, '0, '0, ONES_128, 1'b0, '0},
        '{ROW_BLOCK, '0, '0, FIPS_PT, 1'b0, '0},
        '{ROW_WRITE, REG_KEY_WORD_0, 64'h00010203_04050607, '0, 1'b0, '0},
        '{ROW_WRITE, REG_KEY_WORD_1, 64'h08090a0b_0c0d0e0f, '0, 1'b0, '0},
        '{ROW_BLOCK, '0, '0, FIPS_PT, 1'b1, FIPS_CT_128},
        '{ROW_WRITE, REG_KEY_WORD_2, ONES_64, '0, 1'b0, '0},
        '{ROW_WRITE, REG_KEY_WORD_3, 64'ha5a55a5a_0ff0f00f, '0, 1'b0, '0},
        '{ROW_BLOCK, '0, '0, FIPS_PT, 1'b1, FIPS_CT_128},
        '{ROW_WRITE, REG_KEY_WORD_2, 64'h10111213_14151617, '0, 1'b0, '0},
        '{ROW_WRITE, REG_KEY_WORD_3, 64'h18191a1b_1c1d1e1f, '0, 1'b0, '0},
        '{ROW_WRITE, REG_KEY_SIZE, 64'h1, '0, 1'b0, '0},
        '{ROW_BLOCK, '0, '0, FIPS_PT, 1'b1, FIPS_CT_256},
        '{ROW_WRITE, REG_SPARE_5, ONES_64, '0, 1'b0, '0},
        '{ROW_WRITE, REG_SPARE_6, ONES_64, '0, 1'b0, '0},
        '{ROW_WRITE, REG_SPARE_7, ONES_64, '0, 1'b0, '0},
        '{ROW_BLOCK, '0, '0, FIPS_PT, 1'b1, FIPS_CT_256},
        '{ROW_WRITE, REG_KEY_SIZE, 64'hffffffff_fffffffe, '0, 1'b0, '0},
        '{ROW_BLOCK, '0, '0, FIPS_PT, 1'b1, FIPS_CT_128},
        '{ROW_WRITE, REG_KEY_SIZE, 64'h80000000_00000001, '0, 1'b0, '0},
        '{ROW_BLOCK, '0, '0, FIPS_PT, 1'b1, FIPS_CT_256},
        '{ROW_WRITE, REG_KEY_WORD_0, '0, '0, 1'b0, '0},
        '{ROW_WRITE, REG_KEY_WORD_1, '0, '0, 1'b0, '0},
        '{ROW_WRITE, REG_KEY_WORD_2, '0, '0, 1'b0, '0},
        '{ROW_WRITE, REG_KEY_WORD_3, '0, '0, 1'b0, '0},
        '{ROW_BLOCK, '0, '0, '0, 1'b1, ZERO_CT_256},
        '{ROW_BLOCK, '0, '0, ONES_128, 1'b0, '0},
        '{ROW_WRITE, REG_KEY_WORD_0, ONES_64, '0, 1'b0, '0},
        '{ROW_WRITE, REG_KEY_WORD_1, ONES_64, '0, 1'b0, '0},
        '{ROW_WRITE, REG_KEY_WORD_2, ONES_64, '0, 1'b0, '0},
        '{ROW_WRITE, REG_KEY_WORD_3, ONES_64, '0, 1'b0, '0},
        '{ROW_BLOCK, '0, '0, '0, 1'b0, '0},
        '{ROW_BLOCK, '0, '0, ONES_128, 1'b0, '0},
        '{ROW_WRITE, REG_KEY_SIZE, '0, '0, 1'b0, '0},
        '{ROW_BLOCK, '0, '0, '0, 1'b0, '0},
        '{ROW_BLOCK, '0, '0, ONES_128, 1'b0, '0},
        '{ROW_BLOCK, '0, '0, 128'h55555555_55555555_aaaaaaaa_aaaaaaaa, 1'b0, '0},
        '{ROW_BLOCK, '0, '0, 128'h80000000_00000000_00000000_00000001, 1'b0, '0},
        '{ROW_BLOCK, '0, '0, FIPS_PT, 1'b0, '0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [63:0] plaintext_high = '0;
    logic [63:0] plaintext_low = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] ciphertext_high;
    logic [63:0] ciphertext_low;

    logic         known_ct_valid = 1'b0;
    logic [127:0] known_ct = '0;

    logic [7:0]   sbox_lut [256];
    logic [63:0]  key_words [4];
    logic         key_is_256;
    logic [31:0]  round_key_words [60];
    logic [127:0] ciphertext_due_q [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cycle_count = 0;
    int failures = 0;
    int blocks_sent = 0;
    int results_checked = 0;
    int reg_writes = 0;
    int key_settings = 0;

    aes_block_encrypt_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .plaintext_high  (plaintext_high),
        .plaintext_low   (plaintext_low),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .ciphertext_high (ciphertext_high),
        .ciphertext_low  (ciphertext_low)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic logic [7:0] gf_double(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? REDUCE_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {sbox_lut[w[31:24]], sbox_lut[w[23:16]], sbox_lut[w[15:8]], sbox_lut[w[7:0]]};
    endfunction

    // The state is kept as 16 bytes, byte 4*c+r in the top bits first, so
    // four consecutive schedule words form one 128-bit round key.
    function automatic logic [127:0] round_key(input int rnd);
        return {round_key_words[4*rnd], round_key_words[4*rnd+1],
                round_key_words[4*rnd+2], round_key_words[4*rnd+3]};
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] st);
        logic [127:0] res;
        int c;
        int r;
        for (c = 0; c < 4; c++)
        begin
            for (r = 0; r < 4; r++)
            begin
                res[127-8*(4*c+r) -: 8] = sbox_lut[st[127-8*(4*((c+r)%4)+r) -: 8]];
            end
        end
        return res;
    endfunction

    function automatic void expand_round_keys();
        int nk;
        int total;
        int i;
        logic [7:0]  rcon;
        logic [31:0] t;
        nk = key_is_256 ? 8 : 4;
        total = 4 * ((key_is_256 ? AES256_ROUNDS : AES128_ROUNDS) + 1);
        rcon = RCON_FIRST;
        for (i = 0; i < nk; i++)
        begin
            round_key_words[i] = (i % 2) ? key_words[i/2][31:0] : key_words[i/2][63:32];
        end
        for (i = nk; i < total; i++)
        begin
            t = round_key_words[i-1];
            if (i % nk == 0)
            begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                rcon = gf_double(rcon);
            end
            else if (nk == 8 && i % nk == 4)
            begin
                t = sbox_word(t);
            end
            round_key_words[i] = round_key_words[i-nk] ^ t;
        end
    endfunction

    function automatic void note_reg_write(input logic [2:0] index, input logic [63:0] value);
        logic mapped;
        mapped = 1'b1;
        case (index)
            REG_KEY_WORD_0: key_words[0] = value;
            REG_KEY_WORD_1: key_words[1] = value;
            REG_KEY_WORD_2: key_words[2] = value;
            REG_KEY_WORD_3: key_words[3] = value;
            REG_KEY_SIZE:   key_is_256 = value[0];
            default:        mapped = 1'b0;
        endcase
        if (mapped)
        begin
            expand_round_keys();
        end
    endfunction

    function automatic logic [127:0] encrypt_block(input logic [127:0] plain);
        logic [127:0] st;
        logic [127:0] sh;
        logic [127:0] mixed;
        logic [7:0]   a0;
        logic [7:0]   a1;
        logic [7:0]   a2;
        logic [7:0]   a3;
        logic [7:0]   sum;
        int rounds;
        int rnd;
        int c;
        rounds = key_is_256 ? AES256_ROUNDS : AES128_ROUNDS;
        st = plain ^ round_key(0);
        for (rnd = 1; rnd < rounds; rnd++)
        begin
            sh = sub_shift(st);
            for (c = 0; c < 4; c++)
            begin
                a0 = sh[127-32*c -: 8];
                a1 = sh[119-32*c -: 8];
                a2 = sh[111-32*c -: 8];
                a3 = sh[103-32*c -: 8];
                sum = a0 ^ a1 ^ a2 ^ a3;
                mixed[127-32*c -: 32] = {a0 ^ sum ^ gf_double(a0 ^ a1),
                                         a1 ^ sum ^ gf_double(a1 ^ a2),
                                         a2 ^ sum ^ gf_double(a2 ^ a3),
                                         a3 ^ sum ^ gf_double(a3 ^ a0)};
            end
            st = mixed ^ round_key(rnd);
        end
        return sub_shift(st) ^ round_key(rounds);
    endfunction

    // The S-box is built by walking the multiplicative group with generator 3
    // and its inverse, then applying the affine transform.
    initial
    begin : sbox_fill
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] x;
        p = 8'h01;
        q = 8'h01;
        do
        begin
            p = p ^ gf_double(p);
            q = q ^ {q[6:0], 1'b0};
            q = q ^ {q[5:0], 2'b0};
            q = q ^ {q[3:0], 4'b0};
            if (q[7])
            begin
                q = q ^ 8'h09;
            end
            x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]} ^ {q[3:0], q[7:4]};
            sbox_lut[p] = x ^ AFFINE_C;
        end
        while (p != 8'h01);
        sbox_lut[0] = AFFINE_C;
    end

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    always @(negedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin : result_check
        logic [127:0] due;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (ciphertext_due_q.size() == 0)
                begin
                    note_failure($sformatf("Unexpected item: ciphertext %h_%h",
                                           ciphertext_high, ciphertext_low));
                end
                else
                begin
                    due = ciphertext_due_q.pop_front();
                    if (ciphertext_high !== due[127:64])
                    begin
                        note_failure($sformatf("ciphertext_high: expected %h, got %h",
                                               due[127:64], ciphertext_high));
                    end
                    if (ciphertext_low !== due[63:0])
                    begin
                        note_failure($sformatf("ciphertext_low: expected %h, got %h",
                                               due[63:0], ciphertext_low));
                    end
                    results_checked++;
                end
            end
            if (in_valid && in_ready)
            begin
                ciphertext_due_q.push_back(known_ct_valid ? known_ct
                    : encrypt_block({plaintext_high, plaintext_low}));
                blocks_sent++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout with %0d items outstanding.", ciphertext_due_q.size());
            $display("FAIL aes_block_encrypt_unit");
            $finish;
        end
    end

    task automatic pause_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (ciphertext_due_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        note_reg_write(index, value);
        reg_writes++;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_block(input logic [127:0] plain, input logic known,
                              input logic [127:0] cipher);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
        begin
            gap++;
        end
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        plaintext_high <= plain[127:64];
        plaintext_low <= plain[63:0];
        known_ct_valid <= known;
        known_ct <= cipher;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        int row;
        int mode;
        int phase;
        int w;
        int n;
        int pick;
        logic [63:0]  word;
        logic [127:0] plain;
        tx_idle_pct = TX_IDLE_PCT[0];
        rx_idle_pct = RX_IDLE_PCT[0];
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        for (w = 0; w < 4; w++)
        begin
            key_words[w] = '0;
        end
        key_is_256 = 1'b0;
        expand_round_keys();

        for (row = 0; row < SCRIPT_ROWS; row++)
        begin
            if (SCRIPT[row].kind == ROW_WRITE)
            begin
                write_reg(SCRIPT[row].index, SCRIPT[row].value);
            end
            else
            begin
                send_block(SCRIPT[row].block, SCRIPT[row].known, SCRIPT[row].cipher);
            end
        end

        for (mode = 0; mode < 3; mode++)
        begin
            tx_idle_pct = TX_IDLE_PCT[mode];
            rx_idle_pct = RX_IDLE_PCT[mode];
            for (phase = 0; phase < PHASES_PER_MODE; phase++)
            begin
                pick = $urandom_range(5);
                for (w = 0; w < 4; w++)
                begin
                    word = (pick == 0) ? '0 : (pick == 1) ? ONES_64 : {$urandom, $urandom};
                    write_reg(KEY_WORD_REGS[w], word);
                end
                if ($urandom_range(1) == 1)
                begin
                    write_reg(SPARE_REGS[$urandom_range(2)], {$urandom, $urandom});
                end
                word = {$urandom, $urandom};
                word[0] = phase[0];
                write_reg(REG_KEY_SIZE, word);
                key_settings++;
                for (n = 0; n < BLOCKS_PER_PHASE; n++)
                begin
                    if (n == BLOCKS_PER_PHASE / 2)
                    begin
                        pause_until_drained();
                    end
                    pick = $urandom_range(19);
                    plain = (pick == 0) ? '0 : (pick == 1) ? ONES_128
                          : {$urandom, $urandom, $urandom, $urandom};
                    send_block(plain, 1'b0, '0);
                end
            end
        end

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d ciphertext items for %0d plaintext items under %0d random keys",
                 results_checked, blocks_sent, key_settings);
        $display("plus scripted keys, AES-128 and AES-256, with %0d register writes.",
                 reg_writes);
        if (failures == 0)
        begin
            $display("PASS aes_block_encrypt_unit");
        end
        else
        begin
            $display("%0d failures.", failures);
            $display("FAIL aes_block_encrypt_unit");
        end
        $finish;
    end

endmodule

@@ aes_block_encrypt_unit.f @@
sv/aes_pkg.sv
sv/aes_rk_ram.sv
sv/aes_key_expand.sv
sv/aes_round.sv
sv/aes_block_encrypt_unit.sv
tb/aes_block_encrypt_unit_tb.sv
